// ----- rtl/slsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and register codes for the slit-scan compositor.
// Depends on nothing; every other file imports it.
package slsc_pkg;

   localparam int MAX_WIDTH    = 320;
   localparam int MAX_HEIGHT   = 240;
   localparam int MAX_SLICES   = 16;
   localparam int PIXEL_BITS   = 24;

   localparam int MAX_DIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int SLOT_W       = $clog2(MAX_SLICES);
   localparam int FILL_W       = $clog2(MAX_SLICES + 1);
   localparam int FRAME_PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int STORE_DEPTH  = FRAME_PIXELS * MAX_SLICES;
   localparam int OFS_W        = $clog2(FRAME_PIXELS);
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int DIV_W        = $clog2(MAX_DIM + MAX_SLICES);
   localparam int STEP_W       = $clog2(DIV_W + 1);

   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

   // Register port widths.
   localparam int DIR_W        = 2;
   localparam int SLICES_W     = 5;
   localparam int FWIDTH_W     = 9;
   localparam int FHEIGHT_W    = 8;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 9;
   localparam int NUM_REGS     = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_SLICES   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd3;

   localparam logic [SLICES_W-1:0]  RESET_SLICES = 5'd1;
   localparam logic [FWIDTH_W-1:0]  RESET_WIDTH  = 9'd320;
   localparam logic [FHEIGHT_W-1:0] RESET_HEIGHT = 8'd240;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_SIZE_GO,
      CFG_SIZE_WAIT,
      CFG_START_GO,
      CFG_START_WAIT
   } cfg_state_type;

   // One classified pixel on its way from the front end to the store.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [ADDR_W-1:0]     wr_addr;
      logic [ADDR_W-1:0]     rd_addr;
      logic                  use_live;
      logic                  emit;
      logic                  last;
   } entry_type;

endpackage

// ----- rtl/slit_scan_frame_compositor.sv -----
`timescale 1ns / 1ps
// Slit-scan frame compositor, top level. Instantiates slsc_front, slsc_fifo
// and slsc_back; depends on slsc_pkg.
//
// Pixels arrive on the req_ channel in raster order, one word per clock at
// most; req_frame_start marks the first pixel of a frame. Each word is stored
// into a ring of the last num_slices frames and answered on the rsp_ channel
// with the pixel at the same position taken from the frame that its slice
// selects, once the window holds num_slices frames. rsp_frame_end marks the
// last pixel of a frame. Words before the window is full give no result.
// Throughput is one word per clock while req_ready is high; each result
// passes the queue, then the output register, which the store read fills as
// its word leaves the queue. The csr_ port is always ready. A write to a
// known register index restarts the window and recomputes the slice layout
// on a shared bit-serial divider, which holds req_ready low until setup is
// done. Until the first write, every pixel passes through live. Reset clears
// the counters and setup state and sets the registers to direction up, one
// slice, 320 by 240; the slice layout and the frame store are not cleared.
// When the receiver stalls, the output register holds its word, a four-entry
// queue keeps taking input, and req_ready drops once the queue is full.
module slit_scan_frame_compositor
   import slsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_BITS-1:0]  req_pixel_in,
   input  logic                   req_frame_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIXEL_BITS-1:0]  rsp_pixel_out,
   output logic                   rsp_frame_end
);

   entry_type push_data;
   entry_type head;
   logic      push;
   logic      fifo_full;
   logic      pop;
   logic      head_valid;

   assign csr_ready = 1'b1;

   slsc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .fifo_full       (fifo_full),
      .push            (push),
      .push_data       (push_data)
   );

   slsc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (fifo_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   slsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ----- rtl/slsc_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used for slice setup.
// Depends on slsc_pkg.
module slsc_div
   import slsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/slsc_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, slice setup, raster position and slice
// tracking; classifies each accepted word into a queue entry. Uses slsc_pkg, slsc_div.
module slsc_front
   import slsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_BITS-1:0]  req_pixel_in,
   input  logic                   req_frame_start,
   input  logic                   fifo_full,
   output logic                   push,
   output entry_type              push_data
);

   cfg_state_type state_ff, state_in;

   dir_type              dir_ff, dir_in;
   logic [SLICES_W-1:0]  nsl_ff, nsl_in;
   logic [FWIDTH_W-1:0]  fw_ff, fw_in;
   logic [FHEIGHT_W-1:0] fh_ff, fh_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [OFS_W-1:0]  base_ff, base_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [FILL_W-1:0] filled_ff, filled_in;
   logic [SLOT_W-1:0] sl_idx_ff, sl_idx_in;
   logic [DIV_W-1:0]  sl_rem_ff, sl_rem_in;
   logic              cfg_ok_ff, cfg_ok_in;

   logic [DIV_W-1:0]  ss_ff;
   logic [SLOT_W-1:0] start_q_ff;
   logic [DIV_W-1:0]  start_r_ff;

   logic              csr_wr;
   logic              div_start, div_done, ss_load, start_load;
   logic [DIV_W-1:0]  div_dividend, div_divisor, div_quo, div_rem;

   logic [FILL_W-1:0] n_eff;
   logic [SLOT_W-1:0] n_m1;
   logic [COL_W-1:0]  w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic [DIV_W-1:0]  dim;
   logic              horiz, fwd;

   logic              new_frame;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [OFS_W-1:0]  cur_base;
   logic [SLOT_W-1:0] cur_idx, idx_clip, idx_eff;
   logic [DIV_W-1:0]  cur_rem;
   logic [FILL_W-1:0] newest_inc, rslot_sum;
   logic [SLOT_W-1:0] newest_new, rslot;
   logic [FILL_W-1:0] filled_new;
   logic [OFS_W-1:0]  ofs;
   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic              col_wrap, row_wrap;
   logic [DIV_W:0]    rem_inc;
   logic [SLOT_W-1:0] step_idx;
   logic [DIV_W-1:0]  step_rem;
   logic              reload, advance;

   slsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign csr_wr    = csr_valid && (csr_index < CSR_INDEX_W'(NUM_REGS));
   assign req_ready = (state_ff == CFG_IDLE) && !fifo_full;
   assign push      = req_valid && req_ready;

   // Out-of-range register values are clamped into their legal ranges.
   always_comb begin
      if (nsl_ff == '0) begin
         n_eff = FILL_W'(1);
      end else if (FILL_W'(nsl_ff) > FILL_W'(MAX_SLICES)) begin
         n_eff = FILL_W'(MAX_SLICES);
      end else begin
         n_eff = FILL_W'(nsl_ff);
      end
      if (fw_ff == '0) begin
         w_eff = COL_W'(1);
      end else if (fw_ff > FWIDTH_W'(MAX_WIDTH)) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(fw_ff);
      end
      if (fh_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (fh_ff > FHEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(fh_ff);
      end
      n_m1  = SLOT_W'(n_eff - 1'b1);
      horiz = dir_ff inside {DIR_RIGHT, DIR_LEFT};
      fwd   = dir_ff inside {DIR_RIGHT, DIR_DOWN};
      dim   = horiz ? DIV_W'(w_eff) : DIV_W'(h_eff);
   end

   // Setup sequence: slice size first, then the slice and offset where the
   // counters start: the far edge when slices count backward, else zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      ss_load      = 1'b0;
      start_load   = 1'b0;
      div_dividend = fwd ? '0 : DIV_W'(dim - 1'b1);
      div_divisor  = ss_ff;
      case (state_ff)
         CFG_IDLE: begin
         end
         CFG_SIZE_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(dim + DIV_W'(n_eff) - 1'b1);
            div_divisor  = DIV_W'(n_eff);
            state_in     = CFG_SIZE_WAIT;
         end
         CFG_SIZE_WAIT: begin
            if (div_done) begin
               ss_load  = 1'b1;
               state_in = CFG_START_GO;
            end
         end
         CFG_START_GO: begin
            div_start = 1'b1;
            state_in  = CFG_START_WAIT;
         end
         CFG_START_WAIT: begin
            if (div_done) begin
               start_load = 1'b1;
               state_in   = CFG_IDLE;
            end
         end
         default: begin
            state_in = CFG_IDLE;
         end
      endcase
      if (csr_wr) begin
         state_in = CFG_SIZE_GO;
      end
   end

   always_ff @(posedge clock) begin
      if (ss_load) begin
         ss_ff <= div_quo;
      end
      if (start_load) begin
         start_q_ff <= div_quo[SLOT_W-1:0];
         start_r_ff <= div_rem;
      end
   end

   // Classification of the word at the input.
   always_comb begin
      new_frame = req_frame_start || (col_ff == '0 && row_ff == '0);
      cur_col   = new_frame ? '0 : col_ff;
      cur_row   = new_frame ? '0 : row_ff;
      cur_base  = new_frame ? '0 : base_ff;
      cur_idx   = new_frame ? start_q_ff : sl_idx_ff;
      cur_rem   = new_frame ? start_r_ff : sl_rem_ff;

      newest_inc = FILL_W'(newest_ff) + 1'b1;
      if (!new_frame) begin
         newest_new = newest_ff;
      end else if (newest_inc >= n_eff) begin
         newest_new = '0;
      end else begin
         newest_new = newest_inc[SLOT_W-1:0];
      end
      if (new_frame && filled_ff < FILL_W'(MAX_SLICES)) begin
         filled_new = filled_ff + 1'b1;
      end else begin
         filled_new = filled_ff;
      end

      idx_clip = (cur_idx > n_m1) ? n_m1 : cur_idx;
      idx_eff  = cfg_ok_ff ? idx_clip : '0;

      // Slot of frame idx, oldest first: newest + idx + 1, modulo the window.
      rslot_sum = FILL_W'(newest_new) + FILL_W'(idx_eff) + 1'b1;
      if (rslot_sum >= n_eff) begin
         rslot = SLOT_W'(rslot_sum - n_eff);
      end else begin
         rslot = rslot_sum[SLOT_W-1:0];
      end

      ofs = cur_base + OFS_W'(cur_col);
      push_data.pixel    = req_pixel_in;
      push_data.wr_addr  = ADDR_W'(newest_new) * ADDR_W'(FRAME_PIXELS) + ADDR_W'(ofs);
      push_data.rd_addr  = ADDR_W'(rslot) * ADDR_W'(FRAME_PIXELS) + ADDR_W'(ofs);
      push_data.use_live = (idx_eff == n_m1);
      push_data.emit     = (filled_new >= n_eff);
      push_data.last     = (cur_col == COL_W'(w_eff - 1'b1))
                           && (cur_row == ROW_W'(h_eff - 1'b1));

      col_inc  = {1'b0, cur_col} + 1'b1;
      row_inc  = {1'b0, cur_row} + 1'b1;
      col_wrap = (col_inc >= {1'b0, w_eff});
      row_wrap = col_wrap && (row_inc >= {1'b0, h_eff});

      rem_inc = {1'b0, cur_rem} + 1'b1;
      if (fwd) begin
         if (rem_inc >= {1'b0, ss_ff}) begin
            step_rem = '0;
            step_idx = cur_idx + 1'b1;
         end else begin
            step_rem = rem_inc[DIV_W-1:0];
            step_idx = cur_idx;
         end
      end else begin
         if (cur_rem == '0) begin
            step_rem = ss_ff - 1'b1;
            step_idx = cur_idx - 1'b1;
         end else begin
            step_rem = cur_rem - 1'b1;
            step_idx = cur_idx;
         end
      end
      reload  = horiz ? col_wrap : row_wrap;
      advance = horiz ? 1'b1 : col_wrap;
   end

   // Next state of registers and counters.
   always_comb begin
      dir_in    = dir_ff;
      nsl_in    = nsl_ff;
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      base_in   = base_ff;
      newest_in = newest_ff;
      filled_in = filled_ff;
      sl_idx_in = sl_idx_ff;
      sl_rem_in = sl_rem_ff;
      cfg_ok_in = cfg_ok_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_DIRECTION:    dir_in = dir_type'(csr_data[DIR_W-1:0]);
            REG_NUM_SLICES:   nsl_in = csr_data[SLICES_W-1:0];
            REG_FRAME_WIDTH:  fw_in  = csr_data[FWIDTH_W-1:0];
            REG_FRAME_HEIGHT: fh_in  = csr_data[FHEIGHT_W-1:0];
            default: begin
            end
         endcase
         col_in    = '0;
         row_in    = '0;
         base_in   = '0;
         newest_in = '0;
         filled_in = '0;
         cfg_ok_in = 1'b0;
      end else if (start_load) begin
         sl_idx_in = div_quo[SLOT_W-1:0];
         sl_rem_in = div_rem;
         cfg_ok_in = 1'b1;
      end else if (push) begin
         newest_in = newest_new;
         filled_in = filled_new;
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = row_inc[ROW_W-1:0];
               base_in = cur_base + OFS_W'(MAX_WIDTH);
            end
         end else begin
            col_in  = col_inc[COL_W-1:0];
            row_in  = cur_row;
            base_in = cur_base;
         end
         if (reload) begin
            sl_idx_in = start_q_ff;
            sl_rem_in = start_r_ff;
         end else if (advance) begin
            sl_idx_in = step_idx;
            sl_rem_in = step_rem;
         end else begin
            sl_idx_in = cur_idx;
            sl_rem_in = cur_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= DIR_UP;
         nsl_ff    <= RESET_SLICES;
         fw_ff     <= RESET_WIDTH;
         fh_ff     <= RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         base_ff   <= '0;
         newest_ff <= '0;
         filled_ff <= '0;
         cfg_ok_ff <= 1'b0;
      end else begin
         dir_ff    <= dir_in;
         nsl_ff    <= nsl_in;
         fw_ff     <= fw_in;
         fh_ff     <= fh_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         base_ff   <= base_in;
         newest_ff <= newest_in;
         filled_ff <= filled_in;
         cfg_ok_ff <= cfg_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      sl_idx_ff <= sl_idx_in;
      sl_rem_ff <= sl_rem_in;
   end

endmodule

// ----- rtl/slsc_fifo.sv -----
`timescale 1ns / 1ps
// Short register queue between the front end and the store side.
// Depends on slsc_pkg.
module slsc_fifo
   import slsc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      head_valid
);

   entry_type             slots_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/slsc_back.sv -----
`timescale 1ns / 1ps
// Store side: frame ring memory (one write, one read a cycle) and the output
// register of the result channel. Depends on slsc_pkg.
module slsc_back
   import slsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             head,
   input  logic                  head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                  rsp_frame_end
);

   logic [PIXEL_BITS-1:0] frame_store_mem [STORE_DEPTH];

   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic [PIXEL_BITS-1:0] live_ff;
   logic                  use_live_ff;
   logic                  last_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  load;

   // A word with no result only writes the store, so it may leave the queue
   // even while the output register is held.
   assign pop  = head_valid && (!head.emit || !out_valid_ff || rsp_ready);
   assign load = pop && head.emit;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_store_mem[head.wr_addr] <= head.pixel;
      end
      if (load) begin
         rd_data_ff <= frame_store_mem[head.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         live_ff     <= head.pixel;
         use_live_ff <= head.use_live;
         last_ff     <= head.last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = use_live_ff ? live_ff : rd_data_ff;
   assign rsp_frame_end = last_ff;

endmodule

// ----- tb/slit_scan_frame_compositor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the slit-scan frame compositor.
// Depends on slsc_pkg and slit_scan_frame_compositor; predicts every composite word itself.
module slit_scan_frame_compositor_tb;
   import slsc_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 260;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  frame_end;
   } composite_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIXEL_BITS-1:0]  req_pixel_in = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIXEL_BITS-1:0]  rsp_pixel_out;
   logic                   rsp_frame_end;

   // Registers and window state as the testbench sees them.
   dir_type                cfg_dir = DIR_UP;
   logic [SLICES_W-1:0]    cfg_slices = RESET_SLICES;
   logic [FWIDTH_W-1:0]    cfg_width = RESET_WIDTH;
   logic [FHEIGHT_W-1:0]   cfg_height = RESET_HEIGHT;
   int                     slice_len = 0;
   int                     win_newest = 0;
   int                     win_frames = 0;
   int                     pos_col = 0;
   int                     pos_row = 0;
   logic [PIXEL_BITS-1:0]  frame_mem [int];

   composite_word_type     composite_q [$];
   composite_word_type     head_word;

   int                     sender_gap_pct = 0;
   int                     receiver_stall_pct = 0;
   int                     errors = 0;
   int                     pixels_sent = 0;
   int                     results_checked = 0;
   int                     settings_used = 0;

   slit_scan_frame_compositor dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_frame_end   (rsp_frame_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int slices_now();
      if (cfg_slices == 0) return 1;
      if (cfg_slices > MAX_SLICES) return MAX_SLICES;
      return int'(cfg_slices);
   endfunction

   function automatic int width_now();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int height_now();
      if (cfg_height == 0) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   // Any write to a known register relays out the slices and restarts the window.
   function automatic void load_register(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      int n;
      int dim;
      case (idx)
         REG_DIRECTION:    cfg_dir = dir_type'(data[DIR_W-1:0]);
         REG_NUM_SLICES:   cfg_slices = data[SLICES_W-1:0];
         REG_FRAME_WIDTH:  cfg_width = data[FWIDTH_W-1:0];
         REG_FRAME_HEIGHT: cfg_height = data[FHEIGHT_W-1:0];
         default:          return;
      endcase
      n = slices_now();
      dim = (cfg_dir == DIR_UP || cfg_dir == DIR_DOWN) ? height_now() : width_now();
      slice_len = (dim + n - 1) / n;
      win_newest = 0;
      win_frames = 0;
      pos_col = 0;
      pos_row = 0;
   endfunction

   function automatic void predict_composite(input logic [PIXEL_BITS-1:0] pix,
                                             input logic start);
      int n;
      int w;
      int h;
      int pos;
      int slice;
      int age;
      int slot;
      int addr;
      composite_word_type word;
      n = slices_now();
      w = width_now();
      h = height_now();
      if (start || (pos_col == 0 && pos_row == 0)) begin
         pos_col = 0;
         pos_row = 0;
         win_newest = (win_newest + 1) % n;
         if (win_frames < MAX_SLICES) win_frames++;
      end
      case (cfg_dir)
         DIR_DOWN:  pos = pos_row;
         DIR_UP:    pos = h - 1 - pos_row;
         DIR_RIGHT: pos = pos_col;
         default:   pos = w - 1 - pos_col;
      endcase
      slice = (slice_len == 0) ? 0 : pos / slice_len;
      if (slice > n - 1) slice = n - 1;
      frame_mem[win_newest * FRAME_PIXELS + pos_row * MAX_WIDTH + pos_col] = pix;
      age = n - 1 - slice;
      if (age == 0) begin
         word.pixel = pix;
      end else begin
         slot = (win_newest + n - age) % n;
         addr = slot * FRAME_PIXELS + pos_row * MAX_WIDTH + pos_col;
         word.pixel = frame_mem.exists(addr) ? frame_mem[addr] : '0;
      end
      word.frame_end = (pos_col == w - 1) && (pos_row == h - 1);
      if (win_frames >= n) composite_q = {composite_q, word};
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= h) pos_row = 0;
      end
   endfunction

   // A frame may be cut short only where the positions it skips already hold
   // pixels in the store; otherwise a later frame would read undefined memory.
   function automatic bit rest_of_frame_stored();
      int w;
      int h;
      int r;
      int c;
      w = width_now();
      h = height_now();
      for (r = pos_row; r < h; r++)
         for (c = (r == pos_row) ? pos_col : 0; c < w; c++)
            if (!frame_mem.exists(win_newest * FRAME_PIXELS + r * MAX_WIDTH + c)) return 1'b0;
      return 1'b1;
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin sender_gap_pct = 79; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_gap_pct = 0;  receiver_stall_pct = 79; end
         IDLE_BOTH:     begin sender_gap_pct = 26; receiver_stall_pct = 26; end
         default:       begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic start);
      if (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      predict_composite(pix, start);
   endtask

   task automatic send_pixels(input int count, input logic first_start);
      int i;
      for (i = 0; i < count; i++)
         send_pixel(PIXEL_BITS'($urandom_range(24'hFFFFFF)), (i == 0) ? first_start : 1'b0);
   endtask

   // Waits for every expected word, lets the pipeline settle and for the block
   // to take input again.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (composite_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      load_register(idx, data);
   endtask

   // Writes all four registers in a rotated order, with junk in the unused
   // upper bits, and sometimes an index past the register list at the end.
   task automatic write_config(input logic [DIR_W-1:0] dir, input logic [SLICES_W-1:0] n,
                               input logic [FWIDTH_W-1:0] w, input logic [FHEIGHT_W-1:0] h);
      logic [CSR_DATA_W-1:0] vals [NUM_REGS];
      logic [CSR_DATA_W-1:0] noise;
      int first;
      int k;
      int idx;
      noise = CSR_DATA_W'($urandom_range(511));
      vals[REG_DIRECTION] = {noise[8:2], dir};
      vals[REG_NUM_SLICES] = {noise[8:5], n};
      vals[REG_FRAME_WIDTH] = w;
      vals[REG_FRAME_HEIGHT] = {noise[8], h};
      first = $urandom_range(NUM_REGS - 1);
      for (k = 0; k < NUM_REGS; k++) begin
         idx = (first + k) % NUM_REGS;
         write_reg(CSR_INDEX_W'(idx), vals[idx]);
      end
      if ($urandom_range(3) == 0)
         write_reg(CSR_INDEX_W'($urandom_range(255, NUM_REGS)),
                   CSR_DATA_W'($urandom_range(511)));
      settings_used++;
   endtask

   task automatic test_directed();
      set_idling(IDLE_NONE);
      // Before any write every pixel passes through live.
      send_pixel('0, 1'b1);
      send_pixel('1, 1'b0);
      send_pixel(PIXEL_BITS'($urandom_range(24'hFFFFFF)), 1'b0);
      send_pixel(PIXEL_BITS'($urandom_range(24'hFFFFFF)), 1'b1);
      // Two 2x2 frames, slices counted from the bottom.
      write_config(DIR_UP, 5'd2, 9'd2, 8'd2);
      send_pixels(4, 1'b1);
      send_pixels(4, 1'b0);
      send_pixels(2, 1'b1);
      wait_idle();
      send_pixels(2, 1'b0);
      // This frame is cut short; the next one must see the older bottom row.
      send_pixels(2, 1'b1);
      send_pixels(4, 1'b1);
   endtask

   task automatic test_large_frames();
      set_idling(IDLE_BOTH);
      write_config(DIR_LEFT, 5'd2, 9'd511, 8'd1);
      send_pixels(2 * MAX_WIDTH, 1'b1);
      set_idling(IDLE_RECEIVER);
      write_config(DIR_UP, 5'd1, 9'd1, 8'd255);
      send_pixels(MAX_HEIGHT, 1'b1);
      // One slice as wide as the whole row; the start of a frame is enough.
      set_idling(IDLE_SENDER);
      write_config(DIR_RIGHT, 5'd1, 9'd320, 8'd1);
      send_pixels(MAX_WIDTH / 8, 1'b1);
   endtask

   task automatic test_random_windows();
      int phase;
      int items;
      int target;
      int sel;
      int k;
      int n_val;
      int w_val;
      int h_val;
      logic start;
      phase = 0;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         set_idling(idle_mode_type'(phase % 4));
         sel = (phase < 2) ? phase : $urandom_range(9);
         if (sel == 0) begin
            // Deepest window, clamped from above, on tiny frames.
            n_val = $urandom_range(31, MAX_SLICES);
            w_val = $urandom_range(4, 0);
            h_val = $urandom_range(2, 0);
         end else if (sel == 1) begin
            n_val = 0;
            w_val = $urandom_range(3, 0);
            h_val = $urandom_range(3, 0);
         end else begin
            n_val = $urandom_range(6, 1);
            w_val = $urandom_range(8, 1);
            h_val = $urandom_range(6, 1);
         end
         write_config(DIR_W'($urandom_range(3)), SLICES_W'(n_val),
                      FWIDTH_W'(w_val), FHEIGHT_W'(h_val));
         target = (slices_now() + $urandom_range(4, 1)) * width_now() * height_now();
         for (k = 0; k < target; k++) begin
            if (pos_col == 0 && pos_row == 0)
               start = ($urandom_range(7) != 0);
            else
               start = ($urandom_range(149) == 0) && rest_of_frame_stored();
            if (phase % 3 == 1 && k == target / 2) wait_idle();
            send_pixel(PIXEL_BITS'($urandom_range(24'hFFFFFF)), start);
         end
         items += target;
         phase++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (composite_q.size() == 0) begin
            $error("Unexpected composite word: pixel_out %h, frame_end %b",
                   rsp_pixel_out, rsp_frame_end);
            errors++;
         end else begin
            head_word = composite_q.pop_front();
            if (rsp_pixel_out !== head_word.pixel) begin
               $error("pixel_out: expected %h, got %h", head_word.pixel, rsp_pixel_out);
               errors++;
            end
            if (rsp_frame_end !== head_word.frame_end) begin
               $error("frame_end: expected %b, got %b", head_word.frame_end, rsp_frame_end);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_large_frames();
      test_random_windows();
      wait_idle();
      $display("Sent %0d pixel words over %0d register settings, all four slice orders,",
               pixels_sent, settings_used);
      $display("window depths 1 to 16, with idle and stalled phases; %0d words compared.",
               results_checked);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Run limit reached with %0d composite words outstanding.", composite_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
